// ===== rtl/tmis_pkg.sv =====
// shared types, codes and constants for the three-axis motor interlock sequencer
`default_nettype none
package tmis_pkg;

	localparam int POS_BITS = 16;

	typedef logic [POS_BITS-1:0] pos_t;

	localparam pos_t LIMIT_RESET = '1;
	localparam pos_t CLEAR_RESET = POS_BITS'(30);

	// configuration register indexes
	localparam logic [1:0] REG_BACKREST_LIMIT = 2'd0;
	localparam logic [1:0] REG_LEGREST_LIMIT  = 2'd1;
	localparam logic [1:0] REG_TABLE_LIMIT    = 2'd2;
	localparam logic [1:0] REG_CLEAR_THR      = 2'd3;

	// opcodes
	localparam logic [4:0] OP_TICK       = 5'd0;
	localparam logic [4:0] OP_STOP       = 5'd1;
	localparam logic [4:0] OP_BACK_UP    = 5'd2;
	localparam logic [4:0] OP_BACK_DOWN  = 5'd3;
	localparam logic [4:0] OP_LEG_UP     = 5'd4;
	localparam logic [4:0] OP_LEG_DOWN   = 5'd5;
	localparam logic [4:0] OP_TABLE_FWD  = 5'd6;
	localparam logic [4:0] OP_TABLE_BACK = 5'd7;
	localparam logic [4:0] OP_POSE_LAST  = 5'd13;
	localparam logic [4:0] OP_SPEAKER    = 5'd14;
	localparam logic [4:0] OP_LIGHT      = 5'd15;
	localparam logic [4:0] OP_APP_SET    = 5'd16;

	// owner
	localparam logic [1:0] OWN_NONE   = 2'd0;
	localparam logic [1:0] OWN_MANUAL = 2'd1;
	localparam logic [1:0] OWN_APP    = 2'd2;

	// motor actions
	localparam logic [1:0] ACT_NONE = 2'd0;
	localparam logic [1:0] ACT_STOP = 2'd1;
	localparam logic [1:0] ACT_MOVE = 2'd2;

	// wait codes
	localparam logic [2:0] W_NONE      = 3'd0;
	localparam logic [2:0] W_LEG_UP    = 3'd1;
	localparam logic [2:0] W_LEG_DOWN  = 3'd2;
	localparam logic [2:0] W_TAB_FWD   = 3'd3;
	localparam logic [2:0] W_TAB_BACK  = 3'd4;
	localparam logic [2:0] W_APP_TABLE = 3'd5;
	localparam logic [2:0] W_APP_LEG   = 3'd6;
	localparam logic [2:0] W_DONE      = 3'd7;

	typedef struct packed {
		logic [4:0] opcode;
		pos_t       backrest_now;
		pos_t       legrest_now;
		pos_t       table_now;
		pos_t       goal_backrest;
		pos_t       goal_legrest;
		pos_t       goal_table;
	} in_item_t;

	typedef struct packed {
		logic [1:0] backrest_action;
		pos_t       backrest_dest;
		logic [1:0] legrest_action;
		pos_t       legrest_dest;
		logic [1:0] table_action;
		pos_t       table_dest;
		logic       speaker_on;
		logic       light_on;
		logic [1:0] control_source;
		logic [2:0] wait_code;
	} out_item_t;

	typedef struct packed {
		pos_t backrest_limit;
		pos_t legrest_limit;
		pos_t table_limit;
		pos_t clear_threshold;
	} cfg_t;

	typedef struct packed {
		logic [1:0] owner_mode;
		logic [2:0] wait_phase;
		logic [4:0] previous_command;
		pos_t       target_backrest;
		pos_t       target_legrest;
		pos_t       target_table;
		logic       speaker_flag;
		logic       light_flag;
	} seq_state_t;

endpackage
`default_nettype wire

// ===== rtl/tmis_step.sv =====
// one sequencing step: next state and motor commands for one request
`default_nettype none
module tmis_step (
	input  tmis_pkg::cfg_t       cfg,
	input  tmis_pkg::seq_state_t cur,
	input  tmis_pkg::in_item_t   item,
	output tmis_pkg::seq_state_t nxt,
	output tmis_pkg::out_item_t  res
);
	import tmis_pkg::*;

	logic [4:0] cmd;
	logic [1:0] ba, la, ta;
	pos_t       bd, ld, td;
	pos_t       thr, lnow, tnow;
	seq_state_t s;
	logic       app_done;

	always_comb begin
		s        = cur;
		thr      = cfg.clear_threshold;
		lnow     = item.legrest_now;
		tnow     = item.table_now;
		ba       = ACT_NONE;
		la       = ACT_NONE;
		ta       = ACT_NONE;
		bd       = '0;
		ld       = '0;
		td       = '0;
		app_done = 1'b0;
		cmd      = item.opcode;

		if (item.opcode == OP_APP_SET) begin
			s.target_backrest = item.goal_backrest;
			s.target_legrest  = item.goal_legrest;
			s.target_table    = item.goal_table;
			s.owner_mode      = OWN_APP;
			ba                = ACT_STOP;
			la                = ACT_STOP;
			ta                = ACT_STOP;
			s.wait_phase      = W_NONE;
			cmd               = OP_TICK;
		end else if (item.opcode > OP_APP_SET) begin
			cmd = OP_TICK;
		end

		// manual handling
		if (s.owner_mode != OWN_MANUAL && cmd != OP_TICK) begin
			s.owner_mode = OWN_MANUAL;
			if (cmd >= OP_BACK_UP && cmd <= OP_POSE_LAST) begin
				s.previous_command = OP_TICK;
				ba = ACT_STOP; la = ACT_STOP; ta = ACT_STOP;
				bd = '0; ld = '0; td = '0;
			end
		end
		if (s.owner_mode == OWN_MANUAL) begin
			if ((s.wait_phase == W_LEG_UP || s.wait_phase == W_LEG_DOWN) && tnow < thr) begin
				la = ACT_MOVE;
				ld = (s.wait_phase == W_LEG_UP) ? cfg.legrest_limit : '0;
				s.wait_phase = W_NONE;
			end else if ((s.wait_phase == W_TAB_FWD || s.wait_phase == W_TAB_BACK)
					&& lnow < thr) begin
				ta = ACT_MOVE;
				td = (s.wait_phase == W_TAB_FWD) ? cfg.table_limit : '0;
				s.wait_phase = W_NONE;
			end
			case (cmd)
				OP_STOP: begin
					s.previous_command = cmd;
					ba = ACT_STOP; la = ACT_STOP; ta = ACT_STOP;
					bd = '0; ld = '0; td = '0;
				end
				OP_BACK_UP, OP_BACK_DOWN: begin
					if (s.previous_command != cmd) begin
						ba = ACT_MOVE;
						bd = (cmd == OP_BACK_UP) ? cfg.backrest_limit : '0;
						s.previous_command = cmd;
					end else begin
						ba = ACT_STOP;
						bd = '0;
						s.previous_command = OP_TICK;
					end
				end
				OP_LEG_UP, OP_LEG_DOWN: begin
					if (s.previous_command != cmd) begin
						if (tnow > thr) begin
							s.wait_phase = (cmd == OP_LEG_UP) ? W_LEG_UP : W_LEG_DOWN;
							ta = ACT_MOVE;
							td = '0;
						end else begin
							la = ACT_MOVE;
							ld = (cmd == OP_LEG_UP) ? cfg.legrest_limit : '0;
						end
						s.previous_command = cmd;
					end else begin
						la = ACT_STOP;
						ld = '0;
						s.previous_command = OP_TICK;
					end
				end
				OP_TABLE_FWD, OP_TABLE_BACK: begin
					if (s.previous_command != cmd) begin
						if (lnow > thr) begin
							s.wait_phase = (cmd == OP_TABLE_FWD) ? W_TAB_FWD : W_TAB_BACK;
							la = ACT_MOVE;
							ld = '0;
						end else begin
							ta = ACT_MOVE;
							td = (cmd == OP_TABLE_FWD) ? cfg.table_limit : '0;
						end
						s.previous_command = cmd;
					end else begin
						ta = ACT_STOP;
						td = '0;
						s.previous_command = OP_TICK;
					end
				end
				OP_SPEAKER: s.speaker_flag = ~s.speaker_flag;
				OP_LIGHT:   s.light_flag = ~s.light_flag;
				default: ;
			endcase
		end

		// app handling
		if (s.owner_mode == OWN_APP && s.wait_phase != W_DONE) begin
			if ((s.wait_phase == W_APP_TABLE && tnow < thr) ||
					(s.wait_phase == W_APP_LEG && lnow < thr)) begin
				app_done = 1'b1;
			end else begin
				if (s.target_legrest != '0) begin
					s.target_table = '0;
				end else if (s.target_table != '0) begin
					s.target_legrest = '0;
				end
				if (s.target_legrest != '0 && s.target_table == '0 && tnow > thr) begin
					ta = ACT_MOVE;
					td = '0;
					s.wait_phase = W_APP_TABLE;
				end else if (s.target_table != '0 && s.target_legrest == '0
						&& lnow > thr) begin
					la = ACT_MOVE;
					ld = '0;
					s.wait_phase = W_APP_LEG;
				end else begin
					app_done = 1'b1;
				end
			end
			if (app_done) begin
				ba = ACT_MOVE; bd = s.target_backrest;
				la = ACT_MOVE; ld = s.target_legrest;
				ta = ACT_MOVE; td = s.target_table;
				s.wait_phase = W_DONE;
			end
		end

		nxt                 = s;
		res.backrest_action = ba;
		res.backrest_dest   = bd;
		res.legrest_action  = la;
		res.legrest_dest    = ld;
		res.table_action    = ta;
		res.table_dest      = td;
		res.speaker_on      = s.speaker_flag;
		res.light_on        = s.light_flag;
		res.control_source  = s.owner_mode;
		res.wait_code       = s.wait_phase;
	end

endmodule
`default_nettype wire

// ===== rtl/three_axis_motor_interlock_sequencer.sv =====
// top level: request register, sequencer state, configuration and result register
//
// Takes one request per clock cycle unless a stalled result holds it back, and returns
// one result for each: the request is captured in an input register, the step logic
// computes the next state and the motor commands, and both are registered at the
// same edge into the state and the result register. The state feedback through
// the step logic is the loop that sets the rate of one request per cycle.
// Configuration writes take effect on the next request processed and are
// meant to be made while no request is in flight.
`default_nettype none
module three_axis_motor_interlock_sequencer (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  tmis_pkg::in_item_t   in_data,
	output logic                 out_valid,
	input  wire                  out_stall,
	output tmis_pkg::out_item_t  out_data,
	input  wire                  cfg_we,
	input  wire [1:0]            cfg_index,
	input  tmis_pkg::pos_t       cfg_data
);
	import tmis_pkg::*;

	cfg_t       cfg_q;
	seq_state_t state_q;
	seq_state_t state_nxt;
	in_item_t   item_s1;
	logic       valid_s1;
	out_item_t  res;
	out_item_t  out_q;
	logic       out_valid_q;
	logic       advance;

	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	tmis_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backrest_limit  <= LIMIT_RESET;
			cfg_q.legrest_limit   <= LIMIT_RESET;
			cfg_q.table_limit     <= LIMIT_RESET;
			cfg_q.clear_threshold <= CLEAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BACKREST_LIMIT: cfg_q.backrest_limit  <= cfg_data;
				REG_LEGREST_LIMIT:  cfg_q.legrest_limit   <= cfg_data;
				REG_TABLE_LIMIT:    cfg_q.table_limit     <= cfg_data;
				REG_CLEAR_THR:      cfg_q.clear_threshold <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					state_q <= state_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
		if (advance && valid_s1) begin
			out_q <= res;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/tmis_checker.sv =====
// port-level assertions for the sequencer and their bind to the top level
`default_nettype none
module tmis_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input tmis_pkg::in_item_t  in_data,
	input wire                 out_valid,
	input wire                 out_stall,
	input tmis_pkg::out_item_t out_data
);
	import tmis_pkg::*;

	// a stalled request holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("request changed while stalled");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// destinations are zero unless the axis moves
	a_dest_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(out_data.backrest_action == ACT_MOVE || out_data.backrest_dest == '0) &&
			(out_data.legrest_action == ACT_MOVE || out_data.legrest_dest == '0) &&
			(out_data.table_action == ACT_MOVE || out_data.table_dest == '0))
		else $error("nonzero destination without move");

	// with no owner nothing has been commanded
	a_no_owner: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.control_source == OWN_NONE |->
			out_data.backrest_action == ACT_NONE && out_data.legrest_action == ACT_NONE &&
			out_data.table_action == ACT_NONE && out_data.wait_code == W_NONE)
		else $error("command issued without owner");

	// manual interlock waits only exist under manual control
	a_manual_wait: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.wait_code == W_LEG_UP || out_data.wait_code == W_LEG_DOWN ||
			out_data.wait_code == W_TAB_FWD || out_data.wait_code == W_TAB_BACK) |->
			out_data.control_source == OWN_MANUAL)
		else $error("manual wait outside manual control");

endmodule

bind three_axis_motor_interlock_sequencer tmis_checker u_tmis_checker (.*);
`default_nettype wire
